>>> rtl/core/rcrs_pkg.sv
package rcrs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FW        = 32;
    localparam int HFW       = 30;
    localparam int THRW      = 16;
    localparam int LANES     = 4;
    localparam int DMW       = 2 * FW;
    localparam int QB        = FW - 1;
    localparam int NW        = FW + 2 * FRAC_BITS;
    localparam int IN_W      = 12 * FW;
    localparam int OUT_W     = 6 * FW + 4 * HFW;

    localparam logic [FW-1:0] SAT_POS = {1'b0, {(FW-1){1'b1}}};
    localparam logic [FW-1:0] SAT_NEG = {1'b1, {(FW-1){1'b0}}};

    typedef struct packed {
        logic                  ok;
        logic signed [FW-1:0]  cen_x;
        logic signed [FW-1:0]  cen_y;
        logic [HFW-1:0]        hw;
        logic [HFW-1:0]        hh;
        logic [HFW-1:0]        rx;
        logic [HFW-1:0]        ry;
    } t_side;

    typedef struct packed {
        logic [LANES-1:0]              sat;
        logic [LANES-1:0]              neg;
        logic [LANES-1:0][DMW-1:0]     rem;
        logic [LANES-1:0][QB-1:0]      quo;
        logic [LANES-1:0][QB-1:0]      nlo;
        logic [DMW-1:0]                dmag;
    } t_div;

    typedef struct packed {
        t_side side;
        t_div  div;
    } t_pipe;

endpackage

>>> rtl/core/rcrs_front.sv
module rcrs_front import rcrs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [THRW-1:0] i_det_thr,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [IN_W-1:0] i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output t_pipe           o_data
);

    typedef struct packed {
        logic signed [FW-1:0] a;
        logic signed [FW-1:0] b;
        logic signed [FW-1:0] c;
        logic signed [FW-1:0] d;
        logic signed [FW-1:0] tx;
        logic signed [FW-1:0] ty;
    } t_lin;

    typedef struct packed {
        logic [HFW-1:0] hw;
        logic [HFW-1:0] hh;
        logic [HFW-1:0] rx;
        logic [HFW-1:0] ry;
    } t_dim;

    function automatic logic signed [FW-1:0] f_sat(input logic signed [FW+35-1:0] v);
        if (v > $signed((FW+35)'(SAT_POS))) return SAT_POS;
        else if (v < -$signed((FW+35)'(SAT_POS)) - 1) return SAT_NEG;
        else return v[FW-1:0];
    endfunction

    function automatic logic [FW-1:0] f_mag(input logic signed [FW-1:0] v);
        return v[FW-1] ? FW'(-v) : FW'(v);
    endfunction

    function automatic logic [HFW-1:0] f_clamp(input logic signed [FW-1:0] r,
                                               input logic [HFW-1:0] lim);
        if (r[FW-1]) return '0;
        else if (r[FW-2:0] > (FW-1)'(lim)) return lim;
        else return r[HFW-1:0];
    endfunction

    logic en_a, en_b, en_c, en_d, en_e;
    logic r_va, r_vb, r_vc, r_vd, r_ve;

    // stage A
    t_lin                 n_a_lin, r_a_lin;
    logic signed [FW:0]   n_a_cx, n_a_cy, r_a_cx, r_a_cy;
    t_dim                 n_a_dim, r_a_dim;
    logic                 n_a_ne, r_a_ne;
    // stage B
    t_lin                 r_b_lin;
    logic signed [DMW-1:0] r_b_ad, r_b_bc;
    logic signed [DMW:0]  r_b_p1, r_b_p2, r_b_p3, r_b_p4;
    t_dim                 r_b_dim;
    logic                 r_b_ne;
    // stage C
    t_lin                 r_c_lin;
    logic signed [DMW:0]  r_c_det;
    logic signed [DMW+1:0] r_c_sx, r_c_sy;
    t_dim                 r_c_dim;
    logic                 r_c_ne;
    // stage D
    logic signed [FW-1:0] n_d_cx, n_d_cy, r_d_cx, r_d_cy;
    logic [DMW-1:0]       n_d_dmag, r_d_dmag;
    logic                 r_d_dnz, r_d_ne;
    logic [LANES-1:0]     n_d_neg, r_d_neg;
    logic [LANES-1:0][NW-QB-1:0] n_d_r0, r_d_r0;
    logic [LANES-1:0][QB-1:0]    n_d_nlo, r_d_nlo;
    t_dim                 r_d_dim;
    // stage E
    t_pipe                n_e, r_e;

    assign en_e    = !r_ve || i_ready;
    assign en_d    = !r_vd || en_e;
    assign en_c    = !r_vc || en_d;
    assign en_b    = !r_vb || en_c;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign o_valid = r_ve;
    assign o_data  = r_e;

    always_comb begin
        n_a_lin.a  = i_data[0*FW +: FW];
        n_a_lin.c  = i_data[1*FW +: FW];
        n_a_lin.b  = i_data[2*FW +: FW];
        n_a_lin.d  = i_data[3*FW +: FW];
        n_a_lin.tx = i_data[4*FW +: FW];
        n_a_lin.ty = i_data[5*FW +: FW];
        n_a_dim.hw = i_data[8*FW+1 +: HFW];
        n_a_dim.hh = i_data[9*FW+1 +: HFW];
        n_a_cx = (FW+1)'($signed(i_data[6*FW +: FW])) + $signed({3'b000, n_a_dim.hw});
        n_a_cy = (FW+1)'($signed(i_data[7*FW +: FW])) + $signed({3'b000, n_a_dim.hh});
        n_a_dim.rx = f_clamp(i_data[10*FW +: FW], n_a_dim.hw);
        n_a_dim.ry = f_clamp(i_data[11*FW +: FW], n_a_dim.hh);
        n_a_ne = !i_data[9*FW-1] && (|i_data[8*FW +: FW])
              && !i_data[10*FW-1] && (|i_data[9*FW +: FW]);
    end

    always_comb begin
        n_d_cx = f_sat((FW+35)'(r_c_sx >>> FRAC_BITS) + (FW+35)'(r_c_lin.tx));
        n_d_cy = f_sat((FW+35)'(r_c_sy >>> FRAC_BITS) + (FW+35)'(r_c_lin.ty));
        n_d_dmag = r_c_det[DMW] ? DMW'(-r_c_det) : DMW'(r_c_det);
        n_d_neg[0] = r_c_lin.d[FW-1] ^ r_c_det[DMW];
        n_d_neg[1] = (!r_c_lin.b[FW-1] && (|r_c_lin.b)) ^ r_c_det[DMW];
        n_d_neg[2] = (!r_c_lin.c[FW-1] && (|r_c_lin.c)) ^ r_c_det[DMW];
        n_d_neg[3] = r_c_lin.a[FW-1] ^ r_c_det[DMW];
        {n_d_r0[0], n_d_nlo[0]} = {f_mag(r_c_lin.d), {(2*FRAC_BITS){1'b0}}};
        {n_d_r0[1], n_d_nlo[1]} = {f_mag(r_c_lin.b), {(2*FRAC_BITS){1'b0}}};
        {n_d_r0[2], n_d_nlo[2]} = {f_mag(r_c_lin.c), {(2*FRAC_BITS){1'b0}}};
        {n_d_r0[3], n_d_nlo[3]} = {f_mag(r_c_lin.a), {(2*FRAC_BITS){1'b0}}};
    end

    always_comb begin
        n_e = '0;
        n_e.side.ok = r_d_ne && r_d_dnz
                   && (r_d_dmag >= DMW'({i_det_thr, {FRAC_BITS{1'b0}}}));
        n_e.side.cen_x = r_d_cx;
        n_e.side.cen_y = r_d_cy;
        n_e.side.hw    = r_d_dim.hw;
        n_e.side.hh    = r_d_dim.hh;
        n_e.side.rx    = r_d_dim.rx;
        n_e.side.ry    = r_d_dim.ry;
        n_e.div.neg    = r_d_neg;
        n_e.div.dmag   = r_d_dmag;
        n_e.div.nlo    = r_d_nlo;
        for (int l = 0; l < LANES; l++) begin
            n_e.div.rem[l] = DMW'(r_d_r0[l]);
            n_e.div.sat[l] = DMW'(r_d_r0[l]) >= r_d_dmag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            if (en_a) r_va <= i_valid;
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
            if (en_d) r_vd <= r_vc;
            if (en_e) r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_lin <= n_a_lin;
            r_a_cx  <= n_a_cx;
            r_a_cy  <= n_a_cy;
            r_a_dim <= n_a_dim;
            r_a_ne  <= n_a_ne;
        end
        if (en_b) begin
            r_b_lin <= r_a_lin;
            r_b_ad  <= DMW'(r_a_lin.a) * DMW'(r_a_lin.d);
            r_b_bc  <= DMW'(r_a_lin.b) * DMW'(r_a_lin.c);
            r_b_p1  <= (DMW+1)'(r_a_lin.a) * (DMW+1)'(r_a_cx);
            r_b_p2  <= (DMW+1)'(r_a_lin.b) * (DMW+1)'(r_a_cy);
            r_b_p3  <= (DMW+1)'(r_a_lin.c) * (DMW+1)'(r_a_cx);
            r_b_p4  <= (DMW+1)'(r_a_lin.d) * (DMW+1)'(r_a_cy);
            r_b_dim <= r_a_dim;
            r_b_ne  <= r_a_ne;
        end
        if (en_c) begin
            r_c_lin <= r_b_lin;
            r_c_det <= (DMW+1)'(r_b_ad) - (DMW+1)'(r_b_bc);
            r_c_sx  <= (DMW+2)'(r_b_p1) + (DMW+2)'(r_b_p2);
            r_c_sy  <= (DMW+2)'(r_b_p3) + (DMW+2)'(r_b_p4);
            r_c_dim <= r_b_dim;
            r_c_ne  <= r_b_ne;
        end
        if (en_d) begin
            r_d_cx   <= n_d_cx;
            r_d_cy   <= n_d_cy;
            r_d_dmag <= n_d_dmag;
            r_d_dnz  <= |r_c_det;
            r_d_ne   <= r_c_ne;
            r_d_neg  <= n_d_neg;
            r_d_r0   <= n_d_r0;
            r_d_nlo  <= n_d_nlo;
            r_d_dim  <= r_c_dim;
        end
        if (en_e) begin
            r_e <= n_e;
        end
    end

endmodule

>>> rtl/core/rcrs_div_stage.sv
module rcrs_div_stage import rcrs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_pipe i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_pipe o_data
);

    logic         en;
    logic         r_valid;
    t_pipe        n_data, r_data;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // one restoring quotient bit per lane
    always_comb begin
        logic [DMW:0] t;
        logic         ge;
        n_data = i_data;
        for (int l = 0; l < LANES; l++) begin
            t  = {i_data.div.rem[l], i_data.div.nlo[l][QB-1]};
            ge = t >= {1'b0, i_data.div.dmag};
            n_data.div.rem[l] = ge ? DMW'(t - {1'b0, i_data.div.dmag}) : t[DMW-1:0];
            n_data.div.quo[l] = {i_data.div.quo[l][QB-2:0], ge};
            n_data.div.nlo[l] = {i_data.div.nlo[l][QB-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data <= n_data;
        end
    end

endmodule

>>> rtl/core/rounded_clip_rect_setup.sv
// A word accepted at the input passes through 5 setup stages, 31 divider stages of one quotient bit
// each and 1 output register before it appears on the output.
// Throughput: one word per cycle; each stage holds its word while the next is full.
// Reset (i_rst_n low, synchronous): all stages empty, det_threshold back to 1.
module rounded_clip_rect_setup import rcrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [THRW-1:0]  i_cfg_wdata,  // det_threshold
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // lin_a, lin_c, lin_b, lin_d, shift_x, shift_y, rect_x, rect_y,
    // rect_w, rect_h, radius_x, radius_y
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // inv_00, inv_01, inv_10, inv_11, center_x, center_y,
    // half_width, half_height, clamped_rx, clamped_ry
    output logic [OUT_W-1:0] o_m_tdata,
    output logic             o_m_tuser     // valid_res
);

    logic [THRW-1:0]  r_det_thr;
    t_pipe            w_pipe  [QB+1];
    logic             w_valid [QB+1];
    logic             w_ready [QB+1];
    logic             en_out;
    logic             r_m_tvalid;
    logic [OUT_W-1:0] r_m_tdata, n_m_tdata;
    logic             r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_thr <= THRW'(1);
        end else if (i_cfg_we) begin
            r_det_thr <= i_cfg_wdata;
        end
    end

    rcrs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_det_thr (r_det_thr),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_data    (i_s_tdata),
        .o_valid   (w_valid[0]),
        .i_ready   (w_ready[0]),
        .o_data    (w_pipe[0])
    );

    for (genvar k = 0; k < QB; k++) begin : g_div
        rcrs_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_pipe[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_pipe[k+1])
        );
    end

    assign en_out      = !r_m_tvalid || i_m_tready;
    assign w_ready[QB] = en_out;

    always_comb begin
        logic [LANES-1:0][FW-1:0] inv;
        t_pipe                    p;
        p = w_pipe[QB];
        for (int l = 0; l < LANES; l++) begin
            if (p.div.sat[l]) begin
                inv[l] = p.div.neg[l] ? SAT_NEG : SAT_POS;
            end else begin
                inv[l] = p.div.neg[l] ? FW'(-{1'b0, p.div.quo[l]}) : {1'b0, p.div.quo[l]};
            end
        end
        n_m_tdata = {p.side.ry, p.side.rx, p.side.hh, p.side.hw,
                     p.side.cen_y, p.side.cen_x, inv[3], inv[2], inv[1], inv[0]};
        if (!p.side.ok) begin
            n_m_tdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (en_out) begin
            r_m_tvalid <= w_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_m_tdata <= n_m_tdata;
            r_m_tuser <= w_pipe[QB].side.ok;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("unusable clip word carries nonzero data");

    a_rx_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[6*FW+2*HFW +: HFW] <= o_m_tdata[6*FW +: HFW]))
        else $error("clamped_rx above half_width");

    a_ry_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[6*FW+3*HFW +: HFW] <= o_m_tdata[6*FW+HFW +: HFW]))
        else $error("clamped_ry above half_height");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_det_thr == THRW'(1) && !o_m_tvalid))
        else $error("reset state wrong");

endmodule
